// File: sv/sbc_pkg.sv
// sbc_pkg: shared types, register indexes and saturating fixed-point helpers
// for the swept box collision test. No dependencies.
package sbc_pkg;

  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 20;
  localparam int TAG_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_BITS_D = 12;
  localparam int TAG_COUNT_D = 32;
  localparam int NUM_AXES    = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_Z  = 3'd5;

  // outcome codes
  localparam logic [1:0] OUT_NEVER   = 2'd0;
  localparam logic [1:0] OUT_ALREADY = 2'd1;
  localparam logic [1:0] OUT_HIT     = 2'd2;

  typedef struct packed {
    logic               never;
    logic signed [31:0] t_entry;
    logic signed [31:0] t_exit;
  } axis_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(S32_MAX)) r = S32_MAX;
    else if (v < 34'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // product >> frac, truncating toward zero, saturated
  function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p,
                                                  input int frac);
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [31:0] r;
    mag = p[63] ? (64'd0 - p) : p;
    q   = mag >> frac;
    if (p[63]) begin
      r = (q > 64'h8000_0000) ? S32_MIN : 32'(0 - q);
    end else begin
      r = (q > 64'h7fff_ffff) ? S32_MAX : q[31:0];
    end
    return r;
  endfunction

  // tag reduced modulo count; constant table after elaboration
  function automatic logic [TAG_W-1:0] tag_mod(input logic [TAG_W-1:0] tag,
                                               input int count);
    logic [TAG_W-1:0] res;
    int run;
    res = '0;
    run = 0;
    for (int i = 0; i < (1 << TAG_W); i++) begin
      if (tag == TAG_W'(i)) res = TAG_W'(run);
      run = (run == count - 1) ? 0 : run + 1;
    end
    return res;
  endfunction

endpackage

// File: sv/swept_box_collision_test.sv
// swept_box_collision_test: swept AABB test of one moving box against one
// static obstacle. Depends on sbc_pkg, sbc_recip, sbc_axis.
// Throughput: one transaction per cycle while in_stall is low, through the
// six-stage pipeline (four axis stages, a combine stage and the output
// register); the whole pipe holds on out_stall. A velocity write starts the
// reciprocal divider: in_stall stays high while it runs.
// Reset (synchronous, rst_n low): sizes 1.0, velocities 0, pipe empty.
module swept_box_collision_test #(
  parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_D,
  parameter int TAG_COUNT = sbc_pkg::TAG_COUNT_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_obstacle_min_x,
  input  logic signed [31:0]              in_obstacle_min_y,
  input  logic signed [31:0]              in_obstacle_min_z,
  input  logic signed [31:0]              in_obstacle_max_x,
  input  logic signed [31:0]              in_obstacle_max_y,
  input  logic signed [31:0]              in_obstacle_max_z,
  input  logic signed [31:0]              in_mover_min_x,
  input  logic signed [31:0]              in_mover_min_y,
  input  logic signed [31:0]              in_mover_min_z,
  input  logic [sbc_pkg::TAG_W-1:0]       in_box_tag,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_outcome,
  output logic signed [31:0]              out_hit_time,
  output logic [sbc_pkg::TAG_W-1:0]       out_hit_tag,
  output logic [1:0]                      out_hit_axis
);
  import sbc_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam int AXIS_STAGES = 4;

  // config registers
  logic [SIZE_W-1:0]  size_r [NUM_AXES];
  logic signed [31:0] vel_r  [NUM_AXES];
  logic               vel_wr;

  logic signed [31:0] recip [NUM_AXES];
  logic signed [31:0] nrecip [NUM_AXES];
  logic               div_busy;

  // pipeline control: the whole pipe advances unless the result is stuck
  logic adv;
  logic accept;
  logic [AXIS_STAGES-1:0] vld_r;          // valid bits of axis stages
  logic [TAG_W-1:0]       tag_r [AXIS_STAGES];

  axis_res_t ares [NUM_AXES];

  // combine stage
  logic               c_vld_r;
  logic               c_never_r;
  logic signed [31:0] c_start_r, c_end_r;
  logic [1:0]         c_axis_r;
  logic [TAG_W-1:0]   c_tag_r;

  // output register
  logic               o_vld_r;
  logic [1:0]         o_outcome_r;
  logic signed [31:0] o_time_r;
  logic [TAG_W-1:0]   o_tag_r;
  logic [1:0]         o_axis_r;

  logic signed [31:0] start_c, end_c;
  logic [1:0]         axis_c;
  logic               never_c;

  assign adv      = !(o_vld_r && out_stall);
  assign in_stall = div_busy || !adv;
  assign accept   = in_valid && !in_stall;
  assign vel_wr   = cfg_wr_en &&
                    (cfg_index == REG_VEL_X || cfg_index == REG_VEL_Y ||
                     cfg_index == REG_VEL_Z);

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        size_r[i] <= SIZE_W'(4096);
        vel_r[i]  <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SIZE_X: size_r[0] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_r[1] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_r[2] <= cfg_data[SIZE_W-1:0];
        REG_VEL_X:  vel_r[0]  <= cfg_data;
        REG_VEL_Y:  vel_r[1]  <= cfg_data;
        REG_VEL_Z:  vel_r[2]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // reciprocals only change when a velocity is written
  sbc_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (vel_wr),
    .vel    (vel_r),
    .recip  (recip),
    .nrecip (nrecip),
    .busy   (div_busy)
  );

  sbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .adv(adv),
    .a_min(in_obstacle_min_x), .a_max(in_obstacle_max_x), .b_min(in_mover_min_x),
    .size(size_r[0]), .vel(vel_r[0]), .recip(recip[0]), .nrecip(nrecip[0]),
    .res(ares[0])
  );

  sbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .adv(adv),
    .a_min(in_obstacle_min_y), .a_max(in_obstacle_max_y), .b_min(in_mover_min_y),
    .size(size_r[1]), .vel(vel_r[1]), .recip(recip[1]), .nrecip(nrecip[1]),
    .res(ares[1])
  );

  sbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk(clk), .adv(adv),
    .a_min(in_obstacle_min_z), .a_max(in_obstacle_max_z), .b_min(in_mover_min_z),
    .size(size_r[2]), .vel(vel_r[2]), .recip(recip[2]), .nrecip(nrecip[2]),
    .res(ares[2])
  );

  // valid and tag travel alongside the axis lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[AXIS_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= tag_mod(in_box_tag, TAG_COUNT);
      for (int i = 1; i < AXIS_STAGES; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // latest entry (earliest axis wins a tie), earliest exit
  always_comb begin
    start_c = ares[0].t_entry;
    axis_c  = 2'd0;
    if (ares[1].t_entry > start_c) begin
      start_c = ares[1].t_entry;
      axis_c  = 2'd1;
    end
    if (ares[2].t_entry > start_c) begin
      start_c = ares[2].t_entry;
      axis_c  = 2'd2;
    end
    end_c = ares[0].t_exit;
    if (ares[1].t_exit < end_c) end_c = ares[1].t_exit;
    if (ares[2].t_exit < end_c) end_c = ares[2].t_exit;
    never_c = ares[0].never || ares[1].never || ares[2].never;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= vld_r[AXIS_STAGES-1];
      o_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_never_r <= never_c;
      c_start_r <= start_c;
      c_end_r   <= end_c;
      c_axis_r  <= axis_c;
      c_tag_r   <= tag_r[AXIS_STAGES-1];

      // final classification; unused fields forced to zero
      priority if (c_never_r) begin
        o_outcome_r <= OUT_NEVER;
        o_time_r    <= '0;
        o_tag_r     <= '0;
        o_axis_r    <= '0;
      end else if (c_start_r == -ONE) begin
        o_outcome_r <= OUT_ALREADY;
        o_time_r    <= '0;
        o_tag_r     <= c_tag_r;
        o_axis_r    <= '0;
      end else if (c_start_r > c_end_r || c_start_r >= ONE) begin
        o_outcome_r <= OUT_NEVER;
        o_time_r    <= '0;
        o_tag_r     <= '0;
        o_axis_r    <= '0;
      end else begin
        o_outcome_r <= OUT_HIT;
        o_time_r    <= c_start_r;
        o_tag_r     <= c_tag_r;
        o_axis_r    <= c_axis_r;
      end
    end
  end

  assign out_valid    = o_vld_r;
  assign out_outcome  = o_outcome_r;
  assign out_hit_time = o_time_r;
  assign out_hit_tag  = o_tag_r;
  assign out_hit_axis = o_axis_r;

  // ---- assertions ----
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> in_stall)
    else $error("input taken while reciprocals are updating");

  a_vel_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vel_wr |=> div_busy)
    else $error("velocity write did not start the divider");

  a_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && o_outcome_r == OUT_NEVER) |->
      (o_time_r == 32'sd0 && o_tag_r == '0 && o_axis_r == 2'd0))
    else $error("never transaction carries nonzero fields");

  a_hit_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && o_outcome_r == OUT_HIT) |-> (o_time_r < ONE && o_axis_r != 2'd3))
    else $error("hit transaction with bad time or axis");

endmodule

// File: sv/sbc_recip.sv
// sbc_recip: sequential restoring divider, 2^(2*FRAC_BITS) / vel per axis.
// Depends on sbc_pkg.
module sbc_recip #(
  parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [31:0]       vel [sbc_pkg::NUM_AXES],
  output logic signed [31:0]       recip [sbc_pkg::NUM_AXES],
  output logic signed [31:0]       nrecip [sbc_pkg::NUM_AXES],
  output logic                     busy
);
  import sbc_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t             state_r;
  logic [1:0]         axis_r;
  logic [CW-1:0]      cnt_r;
  logic [31:0]        rem_r;
  logic [QW-1:0]      q_r;
  logic signed [31:0] recip_r [NUM_AXES];
  logic signed [31:0] nrecip_r [NUM_AXES];

  logic signed [31:0] v_cur;
  logic [31:0]        div_mag;
  logic [32:0]        shifted;
  logic [33:0]        trial;
  logic               qbit;
  logic [31:0]        rem_nxt;
  logic [QW-1:0]      q_nxt;
  logic [63:0]        q64;
  logic signed [31:0] r_fin;
  logic signed [31:0] nr_fin;

  always_comb begin
    v_cur   = vel[axis_r];
    div_mag = v_cur[31] ? (32'd0 - v_cur) : v_cur;
    shifted = {rem_r, (cnt_r == CW'(QW - 1))};
    trial   = {1'b0, shifted} - {2'b0, div_mag};
    qbit    = !trial[33];
    rem_nxt = qbit ? trial[31:0] : shifted[31:0];
    q_nxt   = {q_r[QW-2:0], qbit};
    q64     = 64'(q_nxt);
    if (v_cur == 32'sd0) begin
      r_fin = 32'sd0;
    end else if (!v_cur[31]) begin
      r_fin = (q64 > 64'h7fff_ffff) ? S32_MAX : q64[31:0];
    end else begin
      r_fin = (q64 >= 64'h8000_0000) ? S32_MIN : 32'(64'd0 - q64);
    end
    nr_fin = (r_fin == S32_MIN) ? S32_MAX : -r_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      q_r     <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        recip_r[i]  <= '0;
        nrecip_r[i] <= '0;
      end
    end else if (start) begin
      state_r <= ST_RUN;
      axis_r  <= '0;
      cnt_r   <= CW'(QW - 1);
      rem_r   <= '0;
      q_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_RUN: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            recip_r[axis_r]  <= r_fin;
            nrecip_r[axis_r] <= nr_fin;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= CW'(QW - 1);
            if (axis_r == 2'(NUM_AXES - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign recip  = recip_r;
  assign nrecip = nrecip_r;
  assign busy   = (state_r == ST_RUN);

endmodule

// File: sv/sbc_axis.sv
// sbc_axis: four-stage per-axis slab test, entry and exit times of one axis.
// Depends on sbc_pkg.
module sbc_axis #(
  parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_D
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [31:0]            a_min,
  input  logic signed [31:0]            a_max,
  input  logic signed [31:0]            b_min,
  input  logic [sbc_pkg::SIZE_W-1:0]    size,
  input  logic signed [31:0]            vel,
  input  logic signed [31:0]            recip,
  input  logic signed [31:0]            nrecip,
  output sbc_pkg::axis_res_t            res
);
  import sbc_pkg::*;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // stage 1
  logic signed [31:0] s1_amin_r, s1_amax_r, s1_bmin_r, s1_bmax_r;
  // stage 2
  logic               s2_ov_r, s2_vz_r, s2_never_r, s2_touch_r;
  logic signed [31:0] s2_sta_r, s2_ena_r, s2_m_r;
  // stage 3
  logic               s3_ov_r, s3_vz_r, s3_never_r, s3_touch_r;
  logic signed [63:0] s3_stp_r, s3_enp_r;
  // stage 4
  axis_res_t          s4_r;

  logic vpos, vneg, vz, ov;
  logic signed [33:0] amin_e, amax_e, bmin_e, bmax_e;

  always_comb begin
    vz     = (vel == 32'sd0);
    vpos   = !vel[31] && !vz;
    vneg   = vel[31];
    amin_e = 34'(s1_amin_r);
    amax_e = 34'(s1_amax_r);
    bmin_e = 34'(s1_bmin_r);
    bmax_e = 34'(s1_bmax_r);
    ov     = (s1_bmin_r < s1_amax_r) && (s1_amin_r < s1_bmax_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_amin_r <= a_min;
      s1_amax_r <= a_max;
      s1_bmin_r <= b_min;
      s1_bmax_r <= sat32(34'(b_min) + 34'({1'b0, size}));

      s2_ov_r    <= ov;
      s2_vz_r    <= vz;
      s2_never_r <= !ov && (vz || (s1_bmin_r > s1_amax_r && vpos)
                               || (s1_amin_r > s1_bmax_r && vneg));
      s2_touch_r <= vpos ? (s1_amin_r == s1_bmax_r) : (s1_bmin_r == s1_amax_r);
      s2_sta_r   <= vpos ? sat32(amin_e - bmax_e) : sat32(bmin_e - amax_e);
      s2_ena_r   <= vpos ? sat32(amax_e - bmin_e) : sat32(bmax_e - amin_e);
      s2_m_r     <= vpos ? recip : nrecip;

      s3_ov_r    <= s2_ov_r;
      s3_vz_r    <= s2_vz_r;
      s3_never_r <= s2_never_r;
      s3_touch_r <= s2_touch_r;
      s3_stp_r   <= 64'(s2_sta_r) * 64'(s2_m_r);
      s3_enp_r   <= 64'(s2_ena_r) * 64'(s2_m_r);

      s4_r.never   <= s3_never_r;
      s4_r.t_entry <= s3_ov_r ? -ONE :
                      s3_touch_r ? 32'sd1 : fx_scale(s3_stp_r, FRAC_BITS);
      s4_r.t_exit  <= (s3_ov_r && s3_vz_r) ? S32_MAX : fx_scale(s3_enp_r, FRAC_BITS);
    end
  end

  assign res = s4_r;

endmodule
